>>> src/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; simulation gets the checks, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define BJU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
// clocked check, active during reset as well
`define BJU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BJU_ASSERT(lbl, clk, rst_n, prop)
`define BJU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/bju_pkg.sv
// shared types and constants for the board undo journal
// no dependencies
package bju_pkg;

    localparam int CMD_W   = 3;
    localparam int SQ_W    = 6;
    localparam int PC_W    = 4;
    localparam int FILE_W  = 3;
    localparam int DEPTH_W = 8;
    localparam int OP_W    = 7;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_RESET  = 3'd0,
        CMD_START  = 3'd1,
        CMD_SET_SQ = 3'd2,
        CMD_MOVE   = 3'd3,
        CMD_SET_EP = 3'd4,
        CMD_CASTLE = 3'd5,
        CMD_UNDO   = 3'd6,
        CMD_READ   = 3'd7
    } t_cmd;

    // journal operation codes above the square range
    localparam logic [OP_W-1:0] OP_START    = 7'd64;
    localparam logic [OP_W-1:0] OP_SET_EP   = 7'd65;
    localparam logic [OP_W-1:0] OP_CLEAR_EP = 7'd66;
    localparam logic [OP_W-1:0] OP_CASTLE   = 7'd67;

    // journal record
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [PC_W-1:0] val;
    } t_rec;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH2,
        S_MOVE2,
        S_MOVE3,
        S_UNDO_RD,
        S_UNDO_AP,
        S_FETCH,
        S_LOAD
    } t_state;

endpackage

>>> src/bju_in_if.sv
// command channel: valid/ready plus the command word fields
// depends on bju_pkg
interface bju_in_if;
    import bju_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [SQ_W-1:0]   square;
    logic [SQ_W-1:0]   dest_square;
    logic [PC_W-1:0]   write_value;
    logic [FILE_W-1:0] ep_file;

    modport source (output valid, output cmd, output square, output dest_square,
                    output write_value, output ep_file, input ready);
    modport sink   (input valid, input cmd, input square, input dest_square,
                    input write_value, input ep_file, output ready);
endinterface

>>> src/bju_out_if.sv
// result channel: valid/ready plus the result word fields
// depends on bju_pkg
interface bju_out_if;
    import bju_pkg::*;

    logic               valid;
    logic               ready;
    logic [PC_W-1:0]    read_piece;
    logic               ep_valid;
    logic [FILE_W-1:0]  ep_file_out;
    logic [PC_W-1:0]    castle_out;
    logic               side_to_move;
    logic [DEPTH_W-1:0] journal_depth;
    logic               overflow;

    modport source (output valid, output read_piece, output ep_valid, output ep_file_out,
                    output castle_out, output side_to_move, output journal_depth,
                    output overflow, input ready);
    modport sink   (input valid, input read_piece, input ep_valid, input ep_file_out,
                    input castle_out, input side_to_move, input journal_depth,
                    input overflow, output ready);
endinterface

>>> src/board_undo_journal.sv
// board state with undo journal, top level
// depends on bju_pkg, bju_in_if, bju_out_if and assert_macros.svh
//
//  channel   dir   handshake            word
//  i_req     in    valid/ready          cmd, square, dest_square, write_value, ep_file
//  o_rsp     out   valid/ready          read_piece .. overflow, one word per command
//
// per command, from accept to result: start with en passant set pushes a second record;
// move piece journals and writes both squares; undo pops and applies one record per step
// (one journal read port) through the last start record or until the journal is empty
// board squares carry valid bits cleared by reset, so no clearing pass; journal has none
// a new command is taken only in idle, never during reset; a stalled result word holds
// the next command's result load, not its acceptance
`include "assert_macros.svh"

module board_undo_journal #(
    parameter int JOURNAL_DEPTH = 128
) (
    input logic       i_clk,
    input logic       i_rst_n,
    bju_in_if.sink    i_req,
    bju_out_if.source o_rsp
);
    import bju_pkg::*;

    localparam int AW      = $clog2(JOURNAL_DEPTH);
    localparam int TW      = $clog2(JOURNAL_DEPTH + 1);
    localparam int SQUARES = 1 << SQ_W;

    // sequencer and architectural state
    t_state              r_state, n_state;
    logic [TW-1:0]       r_top;
    logic                r_turn;
    logic                r_ep_v;
    logic [FILE_W-1:0]   r_ep_f;
    logic [PC_W-1:0]     r_castle;
    logic                r_was_clear;
    logic [SQUARES-1:0]  r_bvalid;
    logic                r_out_valid;
    logic                r_ovf;

    // latched command word
    t_cmd                r_cmd;
    logic [SQ_W-1:0]     r_sq;
    logic [SQ_W-1:0]     r_dst;
    logic [PC_W-1:0]     r_wv;
    logic [FILE_W-1:0]   r_ef;
    logic [PC_W-1:0]     r_from;

    // memories and their read registers
    logic [PC_W-1:0]     r_board [SQUARES];
    t_rec                r_journal [JOURNAL_DEPTH];
    logic [PC_W-1:0]     r_bq;
    logic                r_bqv;
    t_rec                r_jq;

    // output word registers
    logic [PC_W-1:0]     r_o_piece;
    logic                r_o_ep_v;
    logic [FILE_W-1:0]   r_o_ep_f;
    logic [PC_W-1:0]     r_o_castle;
    logic                r_o_turn;
    logic [DEPTH_W-1:0]  r_o_depth;
    logic                r_o_ovf;

    // control
    logic                in_acc;
    logic                out_load;
    logic [1:0]          need;
    logic [TW-1:0]       free_cnt;
    logic                refused;
    logic [PC_W-1:0]     old_piece;
    logic [SQ_W-1:0]     brd_raddr;
    logic                brd_we;
    logic [SQ_W-1:0]     brd_waddr;
    logic [PC_W-1:0]     brd_wdata;
    logic                jr_we;
    t_rec                jr_wdata;
    logic [AW-1:0]       jr_raddr;
    logic [TW-1:0]       top_m1;
    logic [TW-1:0]       top_m2;
    logic [TW+DEPTH_W-1:0] depth_ext;

    assign in_acc      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && i_rst_n;
    assign out_load    = (r_state == S_LOAD) && (!r_out_valid || o_rsp.ready);
    assign old_piece   = r_bqv ? r_bq : '0;
    assign top_m1      = r_top - TW'(1);
    assign top_m2      = r_top - TW'(2);
    assign depth_ext   = {{DEPTH_W{1'b0}}, r_top};

    // journal records the incoming command needs
    always_comb begin
        case (t_cmd'(i_req.cmd))
            CMD_START:  need = r_ep_v ? 2'd2 : 2'd1;
            CMD_SET_SQ: need = 2'd1;
            CMD_MOVE:   need = 2'd2;
            CMD_SET_EP: need = r_was_clear ? 2'd1 : 2'd0;
            CMD_CASTLE: need = 2'd1;
            default:    need = 2'd0;
        endcase
    end

    assign free_cnt = TW'(JOURNAL_DEPTH) - r_top;
    assign refused  = {{(TW-2){1'b0}}, need} > free_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_ovf) begin
                    n_state = S_LOAD;
                end else begin
                    case (r_cmd)
                        CMD_START:  n_state = r_ep_v ? S_PUSH2 : S_LOAD;
                        CMD_SET_SQ: n_state = S_FETCH;
                        CMD_MOVE:   n_state = S_MOVE2;
                        CMD_UNDO:   n_state = S_UNDO_RD;
                        default:    n_state = S_LOAD;
                    endcase
                end
            end
            S_PUSH2:   n_state = S_LOAD;
            S_MOVE2:   n_state = S_MOVE3;
            S_MOVE3:   n_state = S_FETCH;
            S_UNDO_RD: n_state = (r_top == '0) ? S_FETCH : S_UNDO_AP;
            S_UNDO_AP: begin
                if (r_jq.op == OP_START || r_top == TW'(1)) n_state = S_FETCH;
            end
            S_FETCH:   n_state = S_LOAD;
            S_LOAD: begin
                if (out_load) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // memory ports per state
    always_comb begin
        brd_raddr = r_sq;
        brd_we    = 1'b0;
        brd_waddr = r_sq;
        brd_wdata = '0;
        jr_we     = 1'b0;
        jr_wdata  = '{op: OP_START, val: '0};
        jr_raddr  = top_m1[AW-1:0];
        case (r_state)
            S_IDLE: begin
                brd_raddr = i_req.square;
            end
            S_EXEC: begin
                if (!r_ovf) begin
                    case (r_cmd)
                        CMD_START: begin
                            jr_we = 1'b1;
                        end
                        CMD_SET_SQ: begin
                            jr_we     = 1'b1;
                            jr_wdata  = '{op: {1'b0, r_sq}, val: old_piece};
                            brd_we    = 1'b1;
                            brd_wdata = r_wv;
                        end
                        CMD_MOVE: begin
                            jr_we     = 1'b1;
                            jr_wdata  = '{op: {1'b0, r_sq}, val: old_piece};
                            brd_raddr = r_dst;
                        end
                        CMD_SET_EP: begin
                            jr_we    = r_was_clear;
                            jr_wdata = '{op: OP_CLEAR_EP, val: '0};
                        end
                        CMD_CASTLE: begin
                            jr_we    = 1'b1;
                            jr_wdata = '{op: OP_CASTLE, val: r_castle};
                        end
                        default: begin
                            jr_we = 1'b0;
                        end
                    endcase
                end
            end
            S_PUSH2: begin
                jr_we    = 1'b1;
                jr_wdata = '{op: OP_SET_EP, val: {1'b0, r_ep_f}};
            end
            S_MOVE2: begin
                jr_we     = 1'b1;
                jr_wdata  = '{op: {1'b0, r_dst}, val: old_piece};
                brd_we    = 1'b1;
                brd_waddr = r_dst;
                brd_wdata = r_from;
            end
            S_MOVE3: begin
                brd_we    = 1'b1;
                brd_wdata = '0;
            end
            S_UNDO_AP: begin
                // prefetch the next record while this one is applied
                jr_raddr  = top_m2[AW-1:0];
                brd_we    = !r_jq.op[OP_W-1];
                brd_waddr = r_jq.op[SQ_W-1:0];
                brd_wdata = r_jq.val;
            end
            default: begin
                brd_we = 1'b0;
            end
        endcase
    end

    // board memory
    always_ff @(posedge i_clk) begin
        if (brd_we) r_board[brd_waddr] <= brd_wdata;
        r_bq <= r_board[brd_raddr];
    end

    // journal memory
    always_ff @(posedge i_clk) begin
        if (jr_we) r_journal[r_top[AW-1:0]] <= jr_wdata;
        r_jq <= r_journal[jr_raddr];
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_turn      <= 1'b0;
            r_ep_v      <= 1'b0;
            r_ep_f      <= '0;
            r_castle    <= '0;
            r_was_clear <= 1'b1;
            r_bvalid    <= '0;
            r_bqv       <= 1'b0;
            r_out_valid <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bqv   <= r_bvalid[brd_raddr];
            if (brd_we) r_bvalid[brd_waddr] <= 1'b1;

            if (in_acc) r_ovf <= refused;

            if (jr_we) begin
                r_top <= r_top + TW'(1);
            end else if (r_state == S_EXEC && !r_ovf && r_cmd == CMD_RESET) begin
                r_top <= '0;
            end else if (r_state == S_UNDO_AP) begin
                r_top <= top_m1;
            end

            if (r_state == S_EXEC && !r_ovf) begin
                case (r_cmd)
                    CMD_RESET: r_was_clear <= 1'b1;
                    CMD_START: begin
                        r_turn <= ~r_turn;
                        if (!r_ep_v) r_was_clear <= 1'b1;
                    end
                    CMD_SET_EP: begin
                        r_ep_v <= 1'b1;
                        r_ep_f <= r_ef;
                    end
                    CMD_CASTLE: r_castle <= r_wv;
                    default: begin
                        r_ep_v <= r_ep_v;
                    end
                endcase
            end

            // start with en passant set: second record, then clear
            if (r_state == S_PUSH2) begin
                r_ep_v      <= 1'b0;
                r_ep_f      <= '0;
                r_was_clear <= 1'b0;
            end

            // restore one popped record
            if (r_state == S_UNDO_AP) begin
                case (r_jq.op)
                    OP_START: r_turn <= ~r_turn;
                    OP_CLEAR_EP: begin
                        r_ep_v <= 1'b0;
                        r_ep_f <= '0;
                    end
                    OP_SET_EP: begin
                        r_ep_v <= 1'b1;
                        r_ep_f <= r_jq.val[FILE_W-1:0];
                    end
                    OP_CASTLE: r_castle <= r_jq.val;
                    default: begin
                        r_castle <= r_castle;
                    end
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command word and result word registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= t_cmd'(i_req.cmd);
            r_sq  <= i_req.square;
            r_dst <= i_req.dest_square;
            r_wv  <= i_req.write_value;
            r_ef  <= i_req.ep_file;
        end
        if (r_state == S_EXEC) r_from <= old_piece;
        if (out_load) begin
            r_o_piece  <= old_piece;
            r_o_ep_v   <= r_ep_v;
            r_o_ep_f   <= r_ep_v ? r_ep_f : '0;
            r_o_castle <= r_castle;
            r_o_turn   <= r_turn;
            r_o_depth  <= depth_ext[DEPTH_W-1:0];
            r_o_ovf    <= r_ovf;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_piece    = r_o_piece;
    assign o_rsp.ep_valid      = r_o_ep_v;
    assign o_rsp.ep_file_out   = r_o_ep_f;
    assign o_rsp.castle_out    = r_o_castle;
    assign o_rsp.side_to_move  = r_o_turn;
    assign o_rsp.journal_depth = r_o_depth;
    assign o_rsp.overflow      = r_o_ovf;

    // checks
    `BJU_ASSERT(a_top_bound, i_clk, i_rst_n, r_top <= TW'(JOURNAL_DEPTH))
    `BJU_ASSERT(a_push_room, i_clk, i_rst_n, jr_we |-> (r_top < TW'(JOURNAL_DEPTH)))
    `BJU_ASSERT(a_ovf_hold, i_clk, i_rst_n, (r_state == S_EXEC && r_ovf) |=> $stable(r_top))
    `BJU_ASSERT(a_undo_nonempty, i_clk, i_rst_n, (r_state == S_UNDO_AP) |-> (r_top != '0))

endmodule
